FILE: src/clfl_pkg.sv
// Shared types, constants and helpers for the CAN frame lamp and image loader.
`timescale 1ns / 1ps
`default_nettype none

package clfl_pkg;

    // Image store geometry.
    localparam int PAGE_COUNT     = 256;
    localparam int WORDS_PER_PAGE = 8;
    localparam int STORE_DEPTH    = PAGE_COUNT * WORDS_PER_PAGE;
    localparam int ADDR_W         = $clog2(STORE_DEPTH);
    localparam int ROW_W          = ADDR_W - 1;
    localparam int BANK_DEPTH     = 1 << ROW_W;
    localparam int PAGE_W         = $clog2(PAGE_COUNT + 1);
    localparam int SLOT_W         = $clog2(WORDS_PER_PAGE);
    localparam int CNT_W          = $clog2(STORE_DEPTH + 1);

    // Reset values of the frame identifier registers.
    localparam logic [10:0] LAMP_ID_RESET     = 11'h071;
    localparam logic [10:0] POSITION_ID_RESET = 11'h023;
    localparam logic [10:0] METADATA_ID_RESET = 11'h010;
    localparam logic [10:0] IMAGE_ID_RESET    = 11'h011;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LAMP_ID     = 2'd0;
    localparam logic [1:0] CFG_POSITION_ID = 2'd1;
    localparam logic [1:0] CFG_METADATA_ID = 2'd2;
    localparam logic [1:0] CFG_IMAGE_ID    = 2'd3;

    // Item kinds after classification.
    localparam logic [2:0] KIND_NONE     = 3'd0;
    localparam logic [2:0] KIND_LAMP     = 3'd1;
    localparam logic [2:0] KIND_POSITION = 3'd2;
    localparam logic [2:0] KIND_METADATA = 3'd3;
    localparam logic [2:0] KIND_IMAGE    = 3'd4;
    localparam logic [2:0] KIND_READ     = 3'd5;

    // Action codes of an input beat.
    localparam logic ACTION_FRAME = 1'b0;
    localparam logic ACTION_READ  = 1'b1;

    // Beam values.
    localparam int          LAMP_BIT     = 29;
    localparam logic [7:0]  LAMP_ON_POS  = 8'hC0;

    // Input beat.
    typedef struct packed {
        logic        action;
        logic [10:0] frame_id;
        logic [31:0] data_word0;
        logic [31:0] data_word1;
        logic [7:0]  read_page;
        logic [2:0]  read_slot;
    } in_t;

    // Result beat.
    typedef struct packed {
        logic        beam_on;
        logic [7:0]  beam_left;
        logic [7:0]  beam_right;
        logic        updating;
        logic        image_ready;
        logic [8:0]  pages_filled;
        logic [11:0] words_received;
        logic [31:0] read_data;
    } out_t;

    // Classified command passed from the front part to the back part.
    typedef struct packed {
        logic [2:0]        kind;
        logic [31:0]       data0;
        logic [31:0]       data1;
        logic              rd_ok;
        logic [ADDR_W-1:0] rd_addr;
    } cmd_t;

    // Reverse the byte order of a word.
    function automatic logic [31:0] byte_swap(input logic [31:0] w);
        byte_swap = {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

`default_nettype wire

FILE: src/can_frame_lamp_and_image_loader.sv
// Top level of the CAN frame lamp and image loader.
//
// The loader takes one beat per cycle on s_ while the command queue has room, and
// gives one result beat per input beat on m_, in order. A beat is written into the
// two-entry command queue when it is accepted and is retired into the result register
// by the back part once that register is free or being emptied; throughput holds at
// one beat per cycle while m_ready stays high, and up to two image words are stored
// in the cycle of the retire through even and odd store banks.
// Identifier registers are written on the cfg_ port, index 0 to 3 for lamp,
// position, metadata and image frames, and should change only while the loader is
// idle. There is no clearing pass after reset: the 2048-word image store holds
// undefined data until written, and reading an unwritten word returns whatever it holds.
`timescale 1ns / 1ps
`default_nettype none

module can_frame_lamp_and_image_loader (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [10:0]    cfg_data,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire clfl_pkg::in_t  s_payload,
    output logic                m_valid,
    input  wire logic           m_ready,
    output clfl_pkg::out_t      m_payload
);

    logic           push_valid;
    logic           push_ready;
    clfl_pkg::cmd_t push_cmd;
    logic           pop_valid;
    logic           pop_ready;
    clfl_pkg::cmd_t pop_cmd;

    // Accept and classify.
    clfl_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // Decouple the two sides.
    clfl_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // Execute and present results.
    clfl_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

`default_nettype wire

FILE: src/clfl_front.sv
// Front part: identifier registers, input acceptance and item classification.
`timescale 1ns / 1ps
`default_nettype none

module clfl_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [10:0]      cfg_data,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire clfl_pkg::in_t    s_payload,
    output logic                  push_valid,
    input  wire logic             push_ready,
    output clfl_pkg::cmd_t        push_cmd
);

    logic [10:0] lamp_id_reg;
    logic [10:0] position_id_reg;
    logic [10:0] metadata_id_reg;
    logic [10:0] image_id_reg;
    logic [2:0]  kind;
    logic [31:0] rd_lin;

    // Identifier registers take a write every cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lamp_id_reg     <= clfl_pkg::LAMP_ID_RESET;
            position_id_reg <= clfl_pkg::POSITION_ID_RESET;
            metadata_id_reg <= clfl_pkg::METADATA_ID_RESET;
            image_id_reg    <= clfl_pkg::IMAGE_ID_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                clfl_pkg::CFG_LAMP_ID:     lamp_id_reg     <= cfg_data;
                clfl_pkg::CFG_POSITION_ID: position_id_reg <= cfg_data;
                clfl_pkg::CFG_METADATA_ID: metadata_id_reg <= cfg_data;
                clfl_pkg::CFG_IMAGE_ID:    image_id_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Classify the beat; the lamp role wins over position, metadata and image.
    always_comb begin
        priority if (s_payload.action == clfl_pkg::ACTION_READ) begin
            kind = clfl_pkg::KIND_READ;
        end else if (s_payload.frame_id == lamp_id_reg) begin
            kind = clfl_pkg::KIND_LAMP;
        end else if (s_payload.frame_id == position_id_reg) begin
            kind = clfl_pkg::KIND_POSITION;
        end else if (s_payload.frame_id == metadata_id_reg) begin
            kind = clfl_pkg::KIND_METADATA;
        end else if (s_payload.frame_id == image_id_reg) begin
            kind = clfl_pkg::KIND_IMAGE;
        end else begin
            kind = clfl_pkg::KIND_NONE;
        end
    end

    // Linear store address of a read-back request.
    assign rd_lin = 32'(s_payload.read_page) * 32'(clfl_pkg::WORDS_PER_PAGE)
                  + 32'(s_payload.read_slot);

    // Build the command; image words are byte-swapped here.
    always_comb begin
        push_cmd.kind    = kind;
        push_cmd.data0   = (kind == clfl_pkg::KIND_IMAGE)
                         ? clfl_pkg::byte_swap(s_payload.data_word0)
                         : s_payload.data_word0;
        push_cmd.data1   = clfl_pkg::byte_swap(s_payload.data_word1);
        push_cmd.rd_ok   = (32'(s_payload.read_page) < 32'(clfl_pkg::PAGE_COUNT))
                        && (32'(s_payload.read_slot) < 32'(clfl_pkg::WORDS_PER_PAGE));
        push_cmd.rd_addr = clfl_pkg::ADDR_W'(rd_lin);
    end

    assign push_valid = s_valid;
    assign s_ready    = push_ready;

endmodule

`default_nettype wire

FILE: src/clfl_queue.sv
// Two-entry command queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module clfl_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire clfl_pkg::cmd_t push_cmd,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output clfl_pkg::cmd_t      pop_cmd
);

    clfl_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Occupancy follows pushes and pops in the same cycle.
    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Entry storage carries payload only.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: src/clfl_back.sv
// Back part: beam and loader state, banked image store and result register.
`timescale 1ns / 1ps
`default_nettype none

module clfl_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           pop_valid,
    output logic                pop_ready,
    input  wire clfl_pkg::cmd_t pop_cmd,
    output logic                m_valid,
    input  wire logic           m_ready,
    output clfl_pkg::out_t      m_payload
);

    localparam int ADDR_W       = clfl_pkg::ADDR_W;
    localparam int ROW_W        = clfl_pkg::ROW_W;
    localparam int PAGE_W       = clfl_pkg::PAGE_W;
    localparam int SLOT_W       = clfl_pkg::SLOT_W;
    localparam int CNT_W        = clfl_pkg::CNT_W;
    localparam int BANK_DEPTH_L = clfl_pkg::BANK_DEPTH;

    // Architectural state.
    logic              beam_on_reg,  beam_on_next;
    logic [7:0]        left_reg,     left_next;
    logic [7:0]        right_reg,    right_next;
    logic              upd_reg,      upd_next;
    logic              rdy_reg,      rdy_next;
    logic [31:0]       expected_reg, expected_next;
    logic [PAGE_W-1:0] page_reg,     page_next;
    logic [SLOT_W-1:0] slot_reg,     slot_next;
    logic [CNT_W-1:0]  cnt_reg,      cnt_next;

    // Result register control.
    logic              out_valid_reg;
    logic              out_read_reg;
    logic              out_sel_reg;

    // Image store: even and odd word banks, one write each per cycle.
    logic [31:0]       bank_even [BANK_DEPTH_L];
    logic [31:0]       bank_odd  [BANK_DEPTH_L];
    logic [31:0]       even_q_reg;
    logic [31:0]       odd_q_reg;

    logic              do_pop;
    logic              push_a;
    logic              push_b;
    logic              wrap_a;
    logic              wrap_b;
    logic [PAGE_W-1:0] page_a;
    logic [SLOT_W-1:0] slot_a;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W:0]   addr_b;
    logic [ROW_W-1:0]  row_a;
    logic [ROW_W-1:0]  row_b;
    logic              even_we;
    logic              odd_we;
    logic [ROW_W-1:0]  even_row;
    logic [ROW_W-1:0]  odd_row;
    logic [31:0]       even_wd;
    logic [31:0]       odd_wd;
    logic [ROW_W-1:0]  rd_row;
    logic              is_image;

    // A command retires whenever the result register is free or being emptied.
    assign pop_ready = !out_valid_reg || m_ready;
    assign do_pop    = pop_valid && pop_ready;
    assign is_image  = (pop_cmd.kind == clfl_pkg::KIND_IMAGE);

    // Image append: first word if a page is still due, second if room remains.
    assign push_a = is_image
                 && (page_reg < PAGE_W'(clfl_pkg::PAGE_COUNT))
                 && ((32'(page_reg) * 32'(clfl_pkg::WORDS_PER_PAGE)) < expected_reg);
    assign wrap_a = (slot_reg == SLOT_W'(clfl_pkg::WORDS_PER_PAGE - 1));
    assign page_a = wrap_a ? page_reg + PAGE_W'(1) : page_reg;
    assign slot_a = wrap_a ? '0 : slot_reg + SLOT_W'(1);
    assign push_b = push_a && (page_a < PAGE_W'(clfl_pkg::PAGE_COUNT));
    assign wrap_b = (slot_a == SLOT_W'(clfl_pkg::WORDS_PER_PAGE - 1));

    // The store address of the next word equals the stored word count.
    assign addr_a = ADDR_W'(cnt_reg);
    assign addr_b = {1'b0, addr_a} + (ADDR_W + 1)'(1);
    assign row_a  = ROW_W'(addr_a >> 1);
    assign row_b  = ROW_W'(addr_b >> 1);

    // Steer the two words to the banks by address parity.
    always_comb begin
        if (addr_a[0]) begin
            odd_we   = push_a;
            odd_row  = row_a;
            odd_wd   = pop_cmd.data0;
            even_we  = push_b;
            even_row = row_b;
            even_wd  = pop_cmd.data1;
        end else begin
            even_we  = push_a;
            even_row = row_a;
            even_wd  = pop_cmd.data0;
            odd_we   = push_b;
            odd_row  = row_b;
            odd_wd   = pop_cmd.data1;
        end
    end

    // Next-state logic for one retired command.
    always_comb begin
        beam_on_next  = beam_on_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        upd_next      = upd_reg;
        rdy_next      = rdy_reg;
        expected_next = expected_reg;
        page_next     = page_reg;
        slot_next     = slot_reg;
        cnt_next      = cnt_reg;
        unique case (pop_cmd.kind)
            clfl_pkg::KIND_LAMP: begin
                beam_on_next = pop_cmd.data0[clfl_pkg::LAMP_BIT];
                left_next    = pop_cmd.data0[clfl_pkg::LAMP_BIT] ? clfl_pkg::LAMP_ON_POS : 8'd0;
                right_next   = pop_cmd.data0[clfl_pkg::LAMP_BIT] ? clfl_pkg::LAMP_ON_POS : 8'd0;
            end
            clfl_pkg::KIND_POSITION: begin
                left_next    = pop_cmd.data0[7:0];
                right_next   = pop_cmd.data0[15:8];
                beam_on_next = (pop_cmd.data0[15:0] != 16'd0);
            end
            clfl_pkg::KIND_METADATA: begin
                expected_next = pop_cmd.data0;
                page_next     = '0;
                slot_next     = '0;
                cnt_next      = '0;
                upd_next      = 1'b1;
            end
            clfl_pkg::KIND_IMAGE: begin
                if (push_b) begin
                    page_next = wrap_b ? page_a + PAGE_W'(1) : page_a;
                    slot_next = wrap_b ? '0 : slot_a + SLOT_W'(1);
                    cnt_next  = cnt_reg + CNT_W'(2);
                end else if (push_a) begin
                    page_next = page_a;
                    slot_next = slot_a;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
                if (32'(cnt_next) >= expected_reg) begin
                    rdy_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beam_on_reg   <= 1'b0;
            left_reg      <= '0;
            right_reg     <= '0;
            upd_reg       <= 1'b0;
            rdy_reg       <= 1'b0;
            expected_reg  <= '0;
            page_reg      <= '0;
            slot_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_read_reg  <= 1'b0;
            out_sel_reg   <= 1'b0;
        end else begin
            if (do_pop) begin
                beam_on_reg   <= beam_on_next;
                left_reg      <= left_next;
                right_reg     <= right_next;
                upd_reg       <= upd_next;
                rdy_reg       <= rdy_next;
                expected_reg  <= expected_next;
                page_reg      <= page_next;
                slot_reg      <= slot_next;
                cnt_reg       <= cnt_next;
                out_read_reg  <= (pop_cmd.kind == clfl_pkg::KIND_READ) && pop_cmd.rd_ok;
                out_sel_reg   <= pop_cmd.rd_addr[0];
            end
            if (do_pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Store writes and registered reads; the read port only moves on a retire.
    assign rd_row = ROW_W'(pop_cmd.rd_addr >> 1);

    always_ff @(posedge aclk) begin
        if (do_pop && even_we) begin
            bank_even[even_row] <= even_wd;
        end
        if (do_pop && odd_we) begin
            bank_odd[odd_row] <= odd_wd;
        end
        if (do_pop) begin
            even_q_reg <= bank_even[rd_row];
            odd_q_reg  <= bank_odd[rd_row];
        end
    end

    // The state registers change only on a retire, so they form the result.
    assign m_valid = out_valid_reg;

    always_comb begin
        m_payload.beam_on        = beam_on_reg;
        m_payload.beam_left      = left_reg;
        m_payload.beam_right     = right_reg;
        m_payload.updating       = upd_reg;
        m_payload.image_ready    = rdy_reg;
        m_payload.pages_filled   = 9'(page_reg);
        m_payload.words_received = 12'(cnt_reg);
        m_payload.read_data      = out_read_reg ? (out_sel_reg ? odd_q_reg : even_q_reg)
                                                : 32'd0;
    end

endmodule

`default_nettype wire
